[rtl/ckcb_pkg.sv]
// Shared types, register indexes and widths for the colour-keyed clipped blitter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ckcb_pkg;

  // Default sizing, handed down from the top level as parameters.
  localparam int DefDestPixels = 131072;
  localparam int DefMaxWidth   = 512;

  // Fixed field widths.
  localparam int PIX_W   = 16;
  localparam int COORD_W = 10;
  localparam int KEY_W   = 17;
  localparam int ADDR_W  = 17;
  localparam int ROW_W   = 10;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = KEY_W;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLACE_X    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLACE_Y    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOT   = 4'd7;

  // Current register settings.
  typedef struct packed {
    logic [COORD_W-1:0]        dest_width;
    logic signed [COORD_W-1:0] place_x;
    logic signed [COORD_W-1:0] place_y;
    logic signed [KEY_W-1:0]   transparent_key;
    logic [COORD_W-1:0]        clip_left;
    logic [COORD_W-1:0]        clip_top;
    logic [COORD_W-1:0]        clip_right;
    logic [COORD_W-1:0]        clip_bottom;
  } cfg_t;

  // A pixel that passed the clip and key tests, waiting for its address.
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } q_entry_t;

endpackage

`default_nettype wire

[rtl/ckcb_cfg_regs.sv]
// Configuration register file of the blitter.
// Depends on ckcb_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module ckcb_cfg_regs
  import ckcb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; an unknown index changes nothing.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEST_WIDTH: cfg_d.dest_width      = cfg_data_i[COORD_W-1:0];
        REG_PLACE_X:    cfg_d.place_x         = $signed(cfg_data_i[COORD_W-1:0]);
        REG_PLACE_Y:    cfg_d.place_y         = $signed(cfg_data_i[COORD_W-1:0]);
        REG_KEY:        cfg_d.transparent_key = $signed(cfg_data_i[KEY_W-1:0]);
        REG_CLIP_LEFT:  cfg_d.clip_left       = cfg_data_i[COORD_W-1:0];
        REG_CLIP_TOP:   cfg_d.clip_top        = cfg_data_i[COORD_W-1:0];
        REG_CLIP_RIGHT: cfg_d.clip_right      = cfg_data_i[COORD_W-1:0];
        REG_CLIP_BOT:   cfg_d.clip_bottom     = cfg_data_i[COORD_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  // Reset loads the power-on settings.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_width      <= 10'd320;
      cfg_q.place_x         <= '0;
      cfg_q.place_y         <= '0;
      cfg_q.transparent_key <= '1;
      cfg_q.clip_left       <= '0;
      cfg_q.clip_top        <= '0;
      cfg_q.clip_right      <= 10'd512;
      cfg_q.clip_bottom     <= 10'd240;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/ckcb_front.sv]
// Front end: accepts source pixels, tracks the source position, applies the
// clip rectangle and colour key. Depends on ckcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ckcb_front
  import ckcb_pkg::*;
#(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [PIX_W-1:0] src_pixel_i,
  input  wire logic             row_end_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output q_entry_t              q_entry_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int TX_W  = ((COL_W > COORD_W) ? COL_W : COORD_W) + 2;
  localparam int TY_W  = ROW_W + 2;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = '1;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             accept;

  logic signed [TX_W-1:0] tx, clip_l_x, clip_r_x, width_x;
  logic signed [TY_W-1:0] ty, clip_t_y, clip_b_y;
  logic                   keyed, pass;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Destination position of the current source pixel.
  assign tx = $signed({{(TX_W-COORD_W){cfg_i.place_x[COORD_W-1]}}, cfg_i.place_x})
            + $signed({{(TX_W-COL_W){1'b0}}, col_q});
  assign ty = $signed({{(TY_W-COORD_W){cfg_i.place_y[COORD_W-1]}}, cfg_i.place_y})
            + $signed({2'b00, row_q});

  assign clip_l_x = $signed({{(TX_W-COORD_W){1'b0}}, cfg_i.clip_left});
  assign clip_r_x = $signed({{(TX_W-COORD_W){1'b0}}, cfg_i.clip_right});
  assign width_x  = $signed({{(TX_W-COORD_W){1'b0}}, cfg_i.dest_width});
  assign clip_t_y = $signed({{(TY_W-COORD_W){1'b0}}, cfg_i.clip_top});
  assign clip_b_y = $signed({{(TY_W-COORD_W){1'b0}}, cfg_i.clip_bottom});

  // A non-negative key makes matching pixels transparent.
  assign keyed = !cfg_i.transparent_key[KEY_W-1]
              && (src_pixel_i == cfg_i.transparent_key[PIX_W-1:0]);

  // Right edge is the smaller of clip_right and the row length.
  assign pass = (cfg_i.dest_width != '0)
             && (tx >= clip_l_x) && (tx < clip_r_x) && (tx < width_x)
             && (ty >= clip_t_y) && (ty < clip_b_y) && !keyed;

  assign q_push_o        = accept && pass;
  assign q_entry_o.pixel = src_pixel_i;
  assign q_entry_o.col   = tx[COORD_W-1:0];
  assign q_entry_o.row   = ty[COORD_W-1:0];

  // Source position: the column wraps, the row saturates.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end_i) begin
        col_d = '0;
        if (row_q != ROW_LAST) begin
          row_d = row_q + 1'b1;
        end
      end else if (col_q == COL_LAST) begin
        col_d = '0;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

[rtl/ckcb_queue.sv]
// Short first-in first-out queue between front and back end.
// Depends on ckcb_pkg for the entry type and the depth.
`timescale 1ns / 1ps
`default_nettype none

module ckcb_queue
  import ckcb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t entry_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output q_entry_t      entry_o
);

  q_entry_t mem_q [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

[rtl/ckcb_back.sv]
// Back end: forms the linear address, checks buffer capacity and holds the
// result for the receiver. Depends on ckcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ckcb_back
  import ckcb_pkg::*;
#(
  parameter int DEST_PIXELS = DefDestPixels
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              q_valid_i,
  input  wire q_entry_t          q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ADDR_W-1:0]      dest_address_o,
  output logic [PIX_W-1:0]       dest_pixel_o
);

  localparam logic [SUM_W-1:0] CAPACITY = SUM_W'(DEST_PIXELS);

  // Multiply stage.
  logic                s1_valid_q;
  logic [PROD_W-1:0]   s1_prod_q;
  logic [COORD_W-1:0]  s1_col_q;
  logic [PIX_W-1:0]    s1_pix_q;
  logic                s1_adv, s1_load;

  // Output stage.
  logic                out_valid_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [PIX_W-1:0]    pix_q;

  logic [SUM_W-1:0]    row_end_sum, addr_sum;
  logic                cap_ok;

  assign s1_adv  = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_load = q_valid_i && (!s1_valid_q || s1_adv);
  assign q_pop_o = s1_load;

  // The row lies in the buffer when (row + 1) * dest_width fits in it.
  assign row_end_sum = {1'b0, s1_prod_q} + SUM_W'(cfg_i.dest_width);
  assign cap_ok      = (row_end_sum <= CAPACITY);
  assign addr_sum    = {1'b0, s1_prod_q} + SUM_W'(s1_col_q);

  // Valid flags of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= cap_ok;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Row times stride, then address and colour.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_prod_q <= q_entry_i.row * cfg_i.dest_width;
      s1_col_q  <= q_entry_i.col;
      s1_pix_q  <= q_entry_i.pixel;
    end
    if (s1_adv) begin
      addr_q <= addr_sum[ADDR_W-1:0];
      pix_q  <= s1_pix_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_address_o = addr_q;
  assign dest_pixel_o   = pix_q;

endmodule

`default_nettype wire

[rtl/color_key_clipped_blitter.sv]
// Top level of the colour-keyed, clipped RGB565 blitter.
// Depends on ckcb_pkg, ckcb_cfg_regs, ckcb_front, ckcb_queue and ckcb_back.
//
// Usage: source pixels arrive in raster order on the input channel
// (src_pixel_i, row_end_i, in_valid_i/in_ready_o); row_end_i marks the last
// pixel of a source row. Each pixel that lands inside the clip rectangle, the
// destination row length and the buffer, and that differs from the colour
// key, leaves as one transaction on the output channel (dest_address_o,
// dest_pixel_o, out_valid_o/out_ready_i). Other pixels produce nothing.
// Registers are written through cfg_valid_i/cfg_index_i/cfg_data_i, which is
// always ready; write them only while the block is idle.
// Throughput is one pixel per cycle while the queue is not full. A written pixel
// passes the queue, then the register for the row times stride product, then the
// output register, which takes the address add and capacity test.
// When the receiver stalls, the output register holds its result, the back
// end stops and the four-entry queue fills; the input is refused only once
// the queue is full. Reset clears the source counters and the queue and loads
// the default register settings.
`timescale 1ns / 1ps
`default_nettype none

module color_key_clipped_blitter
  import ckcb_pkg::*;
#(
  parameter int DEST_PIXELS = DefDestPixels,
  parameter int MAX_WIDTH   = DefMaxWidth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [PIX_W-1:0]      src_pixel_i,
  input  wire logic                  row_end_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [ADDR_W-1:0]          dest_address_o,
  output logic [PIX_W-1:0]           dest_pixel_o
);

  cfg_t     cfg;
  q_entry_t push_entry, head_entry;
  logic     q_full, q_push, q_valid, q_pop;

  // Register file.
  ckcb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Position tracking and clip/key classification.
  ckcb_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .src_pixel_i (src_pixel_i),
    .row_end_i   (row_end_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  // Decoupling queue.
  ckcb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  // Address generation and output register.
  ckcb_back #(
    .DEST_PIXELS (DEST_PIXELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_entry_i      (head_entry),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dest_address_o (dest_address_o),
    .dest_pixel_o   (dest_pixel_o)
  );

endmodule

`default_nettype wire
